// ===== sv/word_alu_with_register_file_core_macros.svh =====
// ----------------------------------------------------------------------------
// word alu core assertion macros
// shared concurrent assertion forms for the word alu core
// ----------------------------------------------------------------------------
`ifndef WORD_ALU_WITH_REGISTER_FILE_CORE_MACROS_SVH
`define WORD_ALU_WITH_REGISTER_FILE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define WRF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define WRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wrf_pkg.sv =====
// ----------------------------------------------------------------------------
// wrf_pkg
// shared types and constants of the word alu core
// ----------------------------------------------------------------------------
package wrf_pkg;

    localparam int DEF_NUM_REGS   = 10;
    localparam int DEF_WORD_BITS  = 24;

    localparam int OP_BITS        = 3;
    localparam int FIELD_BITS     = 24;
    localparam int REG_FIELD_BITS = 4;
    localparam int STATUS_BITS    = 2;

    // accumulator is register zero
    localparam int ACC_REG        = 0;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_AND,
        OP_OR,
        OP_XOR,
        OP_NOT
    } wrf_op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK,
        ST_BAD_REG,
        ST_DIV_ZERO
    } wrf_status_t;

    // sequencer to arithmetic unit
    typedef struct packed {
        logic    start;
        wrf_op_t op;
    } wrf_req_t;

    // arithmetic unit to sequencer
    typedef struct packed {
        logic done;
        logic div_zero;
    } wrf_rsp_t;

endpackage

// ===== sv/wrf_regfile.sv =====
// ----------------------------------------------------------------------------
// wrf_regfile
// register file memory, one registered read port and one write port
// ----------------------------------------------------------------------------
module wrf_regfile #(
    parameter int NUM_REGS  = wrf_pkg::DEF_NUM_REGS,
    parameter int WORD_BITS = wrf_pkg::DEF_WORD_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [$clog2(NUM_REGS)-1:0] rd_addr,
    output logic [WORD_BITS-1:0]        rd_data,
    input  logic                        wr_en,
    input  logic [$clog2(NUM_REGS)-1:0] wr_addr,
    input  logic [WORD_BITS-1:0]        wr_data
);
    import wrf_pkg::*;

    logic [WORD_BITS-1:0] mem [NUM_REGS];
    logic [NUM_REGS-1:0]  valid_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;

    // per-entry valid bits stand in for the zero reset of the array
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== sv/wrf_unit.sv =====
// ----------------------------------------------------------------------------
// wrf_unit
// shared adder unit: single-step logic, add and subtract, bit-serial multiply and divide
// ----------------------------------------------------------------------------
module wrf_unit #(
    parameter int WORD_BITS = wrf_pkg::DEF_WORD_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wrf_pkg::wrf_req_t    req,
    input  logic [WORD_BITS-1:0] opa,
    input  logic [WORD_BITS-1:0] opb,
    output wrf_pkg::wrf_rsp_t    rsp,
    output logic [WORD_BITS-1:0] result
);
    import wrf_pkg::*;

    localparam int CntW = $clog2(WORD_BITS);
    localparam logic [CntW-1:0] LastCnt = CntW'(WORD_BITS - 1);

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_ABS_A,
        U_ABS_B,
        U_DIV,
        U_SIGN
    } ustate_t;

    ustate_t              state_reg, state_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] mcd_reg, mcd_next;
    logic [WORD_BITS-1:0] shf_reg, shf_next;
    logic [WORD_BITS-1:0] res_reg, res_next;
    logic [CntW-1:0]      cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic                 done_reg, done_next;
    logic                 dz_reg, dz_next;

    logic [WORD_BITS-1:0] add_x;
    logic [WORD_BITS-1:0] add_y;
    logic                 add_cin;
    logic [WORD_BITS:0]   add_sum;
    logic [WORD_BITS-1:0] trial;

    // partial remainder shifted left with the next dividend bit
    assign trial = {acc_reg[WORD_BITS-2:0], shf_reg[WORD_BITS-1]};

    // operand selection for the one shared adder
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_cin = 1'b0;
        unique case (state_reg)
            U_IDLE:
            begin
                add_x   = opa;
                add_y   = (req.op == OP_SUB) ? ~opb : opb;
                add_cin = (req.op == OP_SUB);
            end
            U_MUL:
            begin
                add_x = acc_reg;
                add_y = shf_reg[0] ? mcd_reg : '0;
            end
            U_ABS_A:
            begin
                add_y   = ~shf_reg;
                add_cin = 1'b1;
            end
            U_ABS_B:
            begin
                add_y   = ~mcd_reg;
                add_cin = 1'b1;
            end
            U_DIV:
            begin
                add_x   = trial;
                add_y   = ~mcd_reg;
                add_cin = 1'b1;
            end
            U_SIGN:
            begin
                add_y   = ~shf_reg;
                add_cin = 1'b1;
            end
            default:
            begin
            end
        endcase
        add_sum = {1'b0, add_x} + {1'b0, add_y} + {{WORD_BITS{1'b0}}, add_cin};
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        mcd_next   = mcd_reg;
        shf_next   = shf_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        dz_next    = 1'b0;
        unique case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    unique case (req.op) inside
                        OP_ADD, OP_SUB:
                        begin
                            res_next  = add_sum[WORD_BITS-1:0];
                            done_next = 1'b1;
                        end
                        OP_AND:
                        begin
                            res_next  = opa & opb;
                            done_next = 1'b1;
                        end
                        OP_OR:
                        begin
                            res_next  = opa | opb;
                            done_next = 1'b1;
                        end
                        OP_XOR:
                        begin
                            res_next  = opa ^ opb;
                            done_next = 1'b1;
                        end
                        OP_NOT:
                        begin
                            res_next  = ~opa;
                            done_next = 1'b1;
                        end
                        OP_MUL:
                        begin
                            acc_next   = '0;
                            mcd_next   = opa;
                            shf_next   = opb;
                            cnt_next   = '0;
                            state_next = U_MUL;
                        end
                        OP_DIV:
                        begin
                            if (opb == '0)
                            begin
                                done_next = 1'b1;
                                dz_next   = 1'b1;
                            end
                            else
                            begin
                                shf_next   = opa;
                                mcd_next   = opb;
                                neg_next   = opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
                                state_next = U_ABS_A;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            U_MUL:
            begin
                // low word of the product, one multiplier bit a cycle
                acc_next = add_sum[WORD_BITS-1:0];
                mcd_next = {mcd_reg[WORD_BITS-2:0], 1'b0};
                shf_next = {1'b0, shf_reg[WORD_BITS-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LastCnt)
                begin
                    res_next   = add_sum[WORD_BITS-1:0];
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
            end
            U_ABS_A:
            begin
                if (shf_reg[WORD_BITS-1])
                begin
                    shf_next = add_sum[WORD_BITS-1:0];
                end
                state_next = U_ABS_B;
            end
            U_ABS_B:
            begin
                if (mcd_reg[WORD_BITS-1])
                begin
                    mcd_next = add_sum[WORD_BITS-1:0];
                end
                acc_next   = '0;
                cnt_next   = '0;
                state_next = U_DIV;
            end
            U_DIV:
            begin
                // restoring step, carry out means the trial subtract fits
                acc_next = add_sum[WORD_BITS] ? add_sum[WORD_BITS-1:0] : trial;
                shf_next = {shf_reg[WORD_BITS-2:0], add_sum[WORD_BITS]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LastCnt)
                begin
                    state_next = U_SIGN;
                end
            end
            U_SIGN:
            begin
                res_next   = neg_reg ? add_sum[WORD_BITS-1:0] : shf_reg;
                done_next  = 1'b1;
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            acc_reg   <= '0;
            mcd_reg   <= '0;
            shf_reg   <= '0;
            res_reg   <= '0;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            done_reg  <= 1'b0;
            dz_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            mcd_reg   <= mcd_next;
            shf_reg   <= shf_next;
            res_reg   <= res_next;
            cnt_reg   <= cnt_next;
            neg_reg   <= neg_next;
            done_reg  <= done_next;
            dz_reg    <= dz_next;
        end
    end

    always_comb
    begin
        rsp.done     = done_reg;
        rsp.div_zero = dz_reg;
    end

    assign result = res_reg;

endmodule

// ===== sv/word_alu_with_register_file_core.sv =====
// ----------------------------------------------------------------------------
// word_alu_with_register_file_core
// signed word alu on a small register file, one instruction per transfer
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  cmd      in         cmd_valid / cmd_stall  opcode register_form mem_operand
//                                             src_reg dst_reg
//  rsp      out        rsp_valid / rsp_stall  status written_reg result_word
//
//  instructions run one at a time: a bad register goes straight to the
//  result, add, sub and logic finish at the launch, and mul and div run
//  the bit-serial adder loop; divide by zero returns after the launch with no loop
//  reset clears the register file at once through per-entry valid bits
//  cmd_stall is high from a cmd transfer until the result sits in the
//  output register; a held result only delays the final load
// ----------------------------------------------------------------------------
`include "word_alu_with_register_file_core_macros.svh"

module word_alu_with_register_file_core #(
    parameter int NUM_REGS  = wrf_pkg::DEF_NUM_REGS,
    parameter int WORD_BITS = wrf_pkg::DEF_WORD_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  logic [wrf_pkg::OP_BITS-1:0]        opcode,
    input  logic                               register_form,
    input  logic [wrf_pkg::FIELD_BITS-1:0]     mem_operand,
    input  logic [wrf_pkg::REG_FIELD_BITS-1:0] src_reg,
    input  logic [wrf_pkg::REG_FIELD_BITS-1:0] dst_reg,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [wrf_pkg::STATUS_BITS-1:0]    status,
    output logic [wrf_pkg::REG_FIELD_BITS-1:0] written_reg,
    output logic [wrf_pkg::FIELD_BITS-1:0]     result_word
);
    import wrf_pkg::*;

    localparam int AddrW = $clog2(NUM_REGS);
    // register count at one bit above the field, so sixteen still fits
    localparam logic [REG_FIELD_BITS:0] RegCount = (REG_FIELD_BITS + 1)'(NUM_REGS);
    localparam logic [AddrW-1:0] AccAddr = AddrW'(ACC_REG);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_A,
        S_READ_B,
        S_LAUNCH,
        S_EXEC,
        S_FINISH
    } state_t;

    // sequencer state and latched instruction
    state_t               state_reg, state_next;
    wrf_op_t              op_reg, op_next;
    logic                 form_reg, form_next;
    logic [WORD_BITS-1:0] operand_reg, operand_next;
    logic [AddrW-1:0]     r1_addr_reg, r1_addr_next;
    logic [AddrW-1:0]     dest_reg, dest_next;
    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [WORD_BITS-1:0] res_reg, res_next;
    wrf_status_t          st_reg, st_next;

    // output register
    logic                      rsp_valid_reg, rsp_valid_next;
    wrf_status_t               status_out_reg, status_out_next;
    logic [REG_FIELD_BITS-1:0] written_out_reg, written_out_next;
    logic [FIELD_BITS-1:0]     result_out_reg, result_out_next;

    logic                 cmd_accept;
    logic                 out_load;
    logic                 bad_reg;
    wrf_op_t              cmd_op;
    logic [WORD_BITS-1:0] cmd_operand;
    logic [FIELD_BITS+WORD_BITS-1:0] operand_ext;
    logic [FIELD_BITS+WORD_BITS-1:0] res_ext;

    // register file and arithmetic unit hookup
    logic [AddrW-1:0]     rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 wr_en;
    wrf_req_t             unit_req;
    wrf_rsp_t             unit_rsp;
    logic [WORD_BITS-1:0] unit_opb;
    logic [WORD_BITS-1:0] unit_result;

    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign cmd_op     = wrf_op_t'(opcode);

    // operand field fitted to the word width, zero filled or cut
    assign operand_ext = {{WORD_BITS{1'b0}}, mem_operand};
    assign cmd_operand = operand_ext[WORD_BITS-1:0];
    assign res_ext     = {{FIELD_BITS{1'b0}}, res_reg};

    // register numbers are checked only in register form; not checks r1 alone
    assign bad_reg = register_form
                     && (({1'b0, src_reg} >= RegCount)
                         || ((cmd_op != OP_NOT) && ({1'b0, dst_reg} >= RegCount)));

    // the result register is free, or its transfer happens this cycle
    assign out_load = (state_reg == S_FINISH) && (!rsp_valid_reg || !rsp_stall);

    // first read fetches the destination, which is always operand a
    assign rd_addr = (state_reg == S_READ_B) ? r1_addr_reg : dest_reg;
    assign wr_en   = out_load && (st_reg == ST_OK);

    always_comb
    begin
        unit_req.start = (state_reg == S_LAUNCH);
        unit_req.op    = op_reg;
        if (!form_reg)
        begin
            unit_opb = operand_reg;
        end
        else if (op_reg == OP_NOT)
        begin
            unit_opb = '0;
        end
        else
        begin
            unit_opb = rd_data;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        form_next        = form_reg;
        operand_next     = operand_reg;
        r1_addr_next     = r1_addr_reg;
        dest_next        = dest_reg;
        a_next           = a_reg;
        res_next         = res_reg;
        st_next          = st_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        status_out_next  = status_out_reg;
        written_out_next = written_out_reg;
        result_out_next  = result_out_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    op_next      = cmd_op;
                    form_next    = register_form;
                    operand_next = cmd_operand;
                    r1_addr_next = src_reg[AddrW-1:0];
                    if (!register_form)
                    begin
                        dest_next = AccAddr;
                    end
                    else if (cmd_op == OP_NOT)
                    begin
                        dest_next = src_reg[AddrW-1:0];
                    end
                    else
                    begin
                        dest_next = dst_reg[AddrW-1:0];
                    end
                    if (bad_reg)
                    begin
                        st_next    = ST_BAD_REG;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        st_next    = ST_OK;
                        state_next = S_READ_A;
                    end
                end
            end
            S_READ_A:
            begin
                state_next = S_READ_B;
            end
            S_READ_B:
            begin
                a_next     = rd_data;
                state_next = S_LAUNCH;
            end
            S_LAUNCH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (unit_rsp.done)
                begin
                    st_next    = unit_rsp.div_zero ? ST_DIV_ZERO : ST_OK;
                    res_next   = unit_result;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    rsp_valid_next  = 1'b1;
                    status_out_next = st_reg;
                    if (st_reg == ST_OK)
                    begin
                        written_out_next = REG_FIELD_BITS'(dest_reg);
                        result_out_next  = res_ext[FIELD_BITS-1:0];
                    end
                    else
                    begin
                        written_out_next = '0;
                        result_out_next  = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_ADD;
            form_reg        <= 1'b0;
            operand_reg     <= '0;
            r1_addr_reg     <= '0;
            dest_reg        <= '0;
            a_reg           <= '0;
            res_reg         <= '0;
            st_reg          <= ST_OK;
            rsp_valid_reg   <= 1'b0;
            status_out_reg  <= ST_OK;
            written_out_reg <= '0;
            result_out_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            form_reg        <= form_next;
            operand_reg     <= operand_next;
            r1_addr_reg     <= r1_addr_next;
            dest_reg        <= dest_next;
            a_reg           <= a_next;
            res_reg         <= res_next;
            st_reg          <= st_next;
            rsp_valid_reg   <= rsp_valid_next;
            status_out_reg  <= status_out_next;
            written_out_reg <= written_out_next;
            result_out_reg  <= result_out_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_out_reg;
    assign written_reg = written_out_reg;
    assign result_word = result_out_reg;

    wrf_regfile #(
        .NUM_REGS  (NUM_REGS),
        .WORD_BITS (WORD_BITS)
    ) u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (dest_reg),
        .wr_data (res_reg)
    );

    wrf_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (unit_req),
        .opa    (a_reg),
        .opb    (unit_opb),
        .rsp    (unit_rsp),
        .result (unit_result)
    );

    // unit completion is only ever seen while the sequencer waits on it
    `WRF_ASSERT_IMPL(a_done_in_exec, clk, rst_n, unit_rsp.done, state_reg == S_EXEC, "unit done outside execute")
    // a cmd transfer always starts work
    `WRF_ASSERT_NEXT(a_busy_after_cmd, clk, rst_n, cmd_accept, cmd_stall, "cmd not stalled after transfer")
    // a good result names a register that exists
    `WRF_ASSERT_IMPL(a_written_in_range, clk, rst_n, rsp_valid && (status == ST_OK), (REG_FIELD_BITS + 1)'(written_reg) < RegCount, "written register out of range")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the word alu core: a queue-fed driver offers
// instructions, an in-order predictor works out each outcome at the cmd
// transfer, and a monitor checks every rsp transfer against it field by field
// ----------------------------------------------------------------------------
module tb_top;
    import wrf_pkg::*;

    localparam int NREGS       = DEF_NUM_REGS;
    localparam int WBITS       = DEF_WORD_BITS;
    localparam int ITEM_COUNT  = 1900;
    // longest honest silence is the long hold-off plus a divide, well below this
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 60;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 160;

    typedef logic [WBITS-1:0] word_t;

    // one instruction plus how it is to be offered
    typedef struct {
        wrf_op_t                   op;
        logic                      form;
        logic [FIELD_BITS-1:0]     operand;
        logic [REG_FIELD_BITS-1:0] r1;
        logic [REG_FIELD_BITS-1:0] r2;
        int unsigned               gap;    // idle cycles before it is offered
        bit                        drain;  // hold back until nothing is in flight
    } instr_t;

    typedef struct {
        wrf_status_t               st;
        logic [REG_FIELD_BITS-1:0] reg_no;
        logic [FIELD_BITS-1:0]     word;
    } outcome_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cmd_valid = 1'b0;
    logic                      cmd_stall;
    logic [OP_BITS-1:0]        opcode = '0;
    logic                      register_form = 1'b0;
    logic [FIELD_BITS-1:0]     mem_operand = '0;
    logic [REG_FIELD_BITS-1:0] src_reg = '0;
    logic [REG_FIELD_BITS-1:0] dst_reg = '0;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    logic [STATUS_BITS-1:0]    status;
    logic [REG_FIELD_BITS-1:0] written_reg;
    logic [FIELD_BITS-1:0]     result_word;

    word_t    gpr [NREGS];            // predicted register file
    instr_t   pending_instrs[$];      // stimulus not yet offered
    outcome_t predicted_results[$];   // outcomes awaiting their rsp transfer

    int n_sent   = 0;
    int n_got    = 0;
    int failures = 0;
    int n_ok     = 0;
    int n_badreg = 0;
    int n_divz   = 0;
    int op_seen [8];
    int n_regform = 0;

    bit drain_next = 1'b0;
    bit steady_run = 1'b0;

    // driver state
    instr_t cur;
    int     gap_left;
    bit     cmd_fire;
    bit     rsp_fire;
    int     inflight;

    // receiver state
    int          phase_left;
    int          hold_left;
    bit          hold_started;
    int unsigned stall_roll;

    int quiet_cycles = 0;

    word_alu_with_register_file_core u_top (.*);

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // word arithmetic in two's complement; returns 0 on a zero divisor
    function automatic bit alu_eval(input wrf_op_t op, input word_t a, input word_t b,
                                    output word_t r);
        logic [WBITS:0] mag_a;
        logic [WBITS:0] mag_b;
        logic [WBITS:0] quo;
        r = '0;
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;    // low word of the product
            OP_DIV:
            begin
                if (b == '0)
                    return 1'b0;
                // magnitudes one bit wider so the most negative value fits
                mag_a = a[WBITS-1] ? {1'b0, ~a} + 1'b1 : {1'b0, a};
                mag_b = b[WBITS-1] ? {1'b0, ~b} + 1'b1 : {1'b0, b};
                quo   = mag_a / mag_b;
                // truncation toward zero; most negative over minus one wraps
                r = (a[WBITS-1] ^ b[WBITS-1]) ? word_t'(~quo + 1'b1) : quo[WBITS-1:0];
            end
            OP_AND: r = a & b;
            OP_OR:  r = a | b;
            OP_XOR: r = a ^ b;
            default: r = ~a;
        endcase
        return 1'b1;
    endfunction

    // executes one instruction against the predicted register file
    function automatic outcome_t execute_instr(input instr_t it);
        outcome_t res;
        int       dest;
        word_t    a;
        word_t    b;
        word_t    r;
        res = '{ST_OK, '0, '0};
        if (!it.form)
        begin
            // accumulator form, register fields unused
            dest = ACC_REG;
            a    = gpr[ACC_REG];
            b    = it.operand[WBITS-1:0];
        end
        else if (it.op == OP_NOT)
        begin
            // register not only looks at the first field
            if (it.r1 >= NREGS)
            begin
                res.st = ST_BAD_REG;
                return res;
            end
            dest = it.r1;
            a    = gpr[it.r1];
            b    = '0;
        end
        else
        begin
            if (it.r1 >= NREGS || it.r2 >= NREGS)
            begin
                res.st = ST_BAD_REG;
                return res;
            end
            dest = it.r2;
            a    = gpr[it.r2];
            b    = gpr[it.r1];
        end
        if (!alu_eval(it.op, a, b, r))
        begin
            res.st = ST_DIV_ZERO;
            return res;
        end
        gpr[dest]  = r;
        res.reg_no = REG_FIELD_BITS'(dest);
        res.word   = FIELD_BITS'(r);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // operand mix: corner words, small signed values, full random words
    function automatic logic [FIELD_BITS-1:0] random_word();
        int unsigned roll;
        int          small_val;
        roll = $urandom_range(0, 99);
        if (roll < 25)
        begin
            case ($urandom_range(0, 5))
                0: return 24'h00_0000;
                1: return 24'h00_0001;
                2: return 24'h7F_FFFF;
                3: return 24'h80_0000;
                4: return 24'hFF_FFFF;
                default: return 24'h00_0002;
            endcase
        end
        if (roll < 50)
        begin
            small_val = $urandom_range(0, 15);
            return $urandom_range(0, 1) ? FIELD_BITS'(-small_val) : FIELD_BITS'(small_val);
        end
        return FIELD_BITS'($urandom());
    endfunction

    // gaps mostly short, a few long, none inside a steady run
    task automatic push_instr(input wrf_op_t op, input logic form,
                              input logic [FIELD_BITS-1:0] operand, input int r1, input int r2);
        instr_t      it;
        int unsigned roll;
        roll       = $urandom_range(0, 99);
        it.op      = op;
        it.form    = form;
        it.operand = operand;
        it.r1      = REG_FIELD_BITS'(r1);
        it.r2      = REG_FIELD_BITS'(r2);
        if (steady_run || roll < 40)
            it.gap = 0;
        else if (roll < 85)
            it.gap = $urandom_range(1, 3);
        else if (roll < 97)
            it.gap = $urandom_range(4, 12);
        else
            it.gap = $urandom_range(20, 60);
        it.drain   = drain_next;
        drain_next = 1'b0;
        pending_instrs.push_back(it);
    endtask

    // puts a known word into register k by way of the accumulator
    task automatic load_reg(input int k, input logic [FIELD_BITS-1:0] value);
        push_instr(OP_AND, 1'b0, '0, 0, 0);
        push_instr(OP_OR, 1'b0, value, 0, 0);
        if (k != ACC_REG)
        begin
            push_instr(OP_XOR, 1'b1, random_word(), k, k);          // clear rk
            push_instr(OP_ADD, 1'b1, random_word(), ACC_REG, k);    // rk = A
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            failures++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus, end of run and summary
    // ------------------------------------------------------------------
    initial
    begin
        int          total;
        int          drain_bucket;
        int unsigned roll;
        int          k;
        int          j;
        int          r1;
        int          r2;

        // directed part: accumulator corners
        push_instr(OP_ADD, 1'b0, 24'h7F_FFFF, 0, 0);
        push_instr(OP_ADD, 1'b0, 24'h00_0001, 0, 0);    // signed overflow wraps
        push_instr(OP_SUB, 1'b0, 24'h00_0001, 0, 0);
        push_instr(OP_MUL, 1'b0, 24'hFF_FFFF, 0, 0);    // times minus one
        push_instr(OP_DIV, 1'b0, 24'h00_0000, 0, 0);    // divide by zero, no write
        push_instr(OP_DIV, 1'b0, 24'hFF_FFFF, 0, 0);
        push_instr(OP_AND, 1'b0, 24'h00_0000, 0, 0);
        push_instr(OP_OR,  1'b0, 24'h80_0000, 0, 0);
        push_instr(OP_DIV, 1'b0, 24'hFF_FFFF, 0, 0);    // most negative over minus one
        push_instr(OP_XOR, 1'b0, 24'hFF_FFFF, 0, 0);
        push_instr(OP_NOT, 1'b0, 24'hAB_CDEF, 15, 15);  // operand and fields ignored
        // truncation toward zero of a negative quotient
        load_reg(ACC_REG, 24'hFF_FFF9);
        push_instr(OP_DIV, 1'b0, 24'h00_0002, 0, 0);
        // register form
        load_reg(9, 24'h80_0000);
        push_instr(OP_SUB, 1'b1, 24'hFF_FFFF, 9, 9);    // r9 to zero
        push_instr(OP_DIV, 1'b1, 24'h00_0000, 9, 0);    // divide by zero register
        push_instr(OP_MUL, 1'b1, 24'h12_3456, 0, 0);
        push_instr(OP_AND, 1'b1, 24'h00_0000, 0, 5);
        push_instr(OP_OR,  1'b1, 24'hFF_FFFF, 0, 5);
        push_instr(OP_XOR, 1'b1, 24'h55_AAAA, 5, 9);
        push_instr(OP_NOT, 1'b1, 24'h00_0000, 9, 15);   // not ignores a bad destination
        push_instr(OP_NOT, 1'b1, 24'h00_0000, 10, 0);   // not with a bad source
        push_instr(OP_ADD, 1'b1, 24'h00_0000, 15, 0);   // bad source
        push_instr(OP_SUB, 1'b1, 24'h00_0000, 0, 10);   // bad destination
        push_instr(OP_DIV, 1'b1, 24'hFF_FFFF, 12, 13);  // both bad

        // random part, the first instruction waits for the directed part
        drain_next   = 1'b1;
        drain_bucket = 0;
        while (pending_instrs.size() < ITEM_COUNT)
        begin
            // a pause for a full drain every few hundred instructions
            if (pending_instrs.size() / 400 != drain_bucket)
            begin
                drain_bucket = pending_instrs.size() / 400;
                drain_next   = 1'b1;
            end
            steady_run = (pending_instrs.size() % 500) < 60;
            roll = $urandom_range(0, 99);
            if (roll < 8)
                load_reg($urandom_range(0, NREGS - 1), random_word());
            else if (roll < 13)
            begin
                // zero a register then divide by it
                k = $urandom_range(0, NREGS - 1);
                j = $urandom_range(0, NREGS - 1);
                push_instr(OP_XOR, 1'b1, random_word(), k, k);
                push_instr(OP_DIV, 1'b1, random_word(), k, j);
            end
            else if (roll < 23)
            begin
                // register form with at least one field out of range
                r1 = $urandom_range(0, 15);
                r2 = $urandom_range(0, 15);
                if ($urandom_range(0, 1))
                    r1 = $urandom_range(NREGS, 15);
                else
                    r2 = $urandom_range(NREGS, 15);
                push_instr(wrf_op_t'($urandom_range(0, 7)), 1'b1, random_word(), r1, r2);
            end
            else
                push_instr(wrf_op_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                           random_word(), $urandom_range(0, NREGS - 1),
                           $urandom_range(0, NREGS - 1));
        end
        total = pending_instrs.size();

        wait (n_got >= total);
        // let any stray result show itself
        repeat (TAIL_CYCLES) @(posedge clk);
        if (predicted_results.size() != 0)
        begin
            failures++;
            $display("%0t ns: %0d results never arrived", $time, predicted_results.size());
        end
        $display("covered %0d instructions (%0d register form): %0d ok, %0d bad register, %0d divide by zero",
                 n_sent, n_regform, n_ok, n_badreg, n_divz);
        $display("per opcode add %0d sub %0d mul %0d div %0d and %0d or %0d xor %0d not %0d",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3],
                 op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // driver: predicts at each cmd transfer, then offers the next item
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            gap_left = 0;
            foreach (gpr[i])
                gpr[i] = '0;
            foreach (op_seen[i])
                op_seen[i] = 0;
        end
        else
        begin
            cmd_fire = cmd_valid && !cmd_stall;
            rsp_fire = rsp_valid && !rsp_stall;
            if (cmd_fire)
            begin
                predicted_results.push_back(execute_instr(cur));
                op_seen[cur.op]++;
                if (cur.form)
                    n_regform++;
                n_sent <= n_sent + 1;
                if (pending_instrs.size() > 0)
                    gap_left = pending_instrs[0].gap;
            end
            // instructions still owed a result once this edge has passed
            inflight = n_sent + int'(cmd_fire) - n_got - int'(rsp_fire);

            if (cmd_valid && !cmd_fire)
                ;   // stalled, payload held as it is
            else if (gap_left > 0)
            begin
                gap_left--;
                cmd_valid <= 1'b0;
            end
            else if (pending_instrs.size() > 0 && (!pending_instrs[0].drain || inflight == 0))
            begin
                cur = pending_instrs.pop_front();
                opcode        <= cur.op;
                register_form <= cur.form;
                mem_operand   <= cur.operand;
                src_reg       <= cur.r1;
                dst_reg       <= cur.r2;
                cmd_valid     <= 1'b1;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // receiver stall pattern, with one long hold-off so the core backs up
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            phase_left   = 0;
            hold_left    = 0;
            hold_started = 1'b0;
        end
        else
        begin
            if (!hold_started && n_got >= HOLD_AT)
            begin
                hold_started = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if ((n_got % 500) >= 200 && (n_got % 500) < 260)
                rsp_stall <= 1'b0;   // steady stretch, no back-pressure
            else if (phase_left > 0)
                phase_left--;
            else
            begin
                stall_roll = $urandom_range(0, 99);
                if (stall_roll < 55)
                begin
                    rsp_stall <= 1'b0;
                    phase_left = $urandom_range(0, 7);
                end
                else if (stall_roll < 92)
                begin
                    rsp_stall <= 1'b1;
                    phase_left = $urandom_range(0, 2);
                end
                else
                begin
                    rsp_stall <= 1'b1;
                    phase_left = $urandom_range(10, 40);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: every rsp transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            n_got <= n_got + 1;
            if (predicted_results.size() == 0)
            begin
                failures++;
                $display("%0t ns: result with nothing outstanding, got status %0d reg %0d word 0x%0h",
                         $time, status, written_reg, result_word);
            end
            else
            begin
                want = predicted_results.pop_front();
                case (want.st)
                    ST_OK:      n_ok++;
                    ST_BAD_REG: n_badreg++;
                    default:    n_divz++;
                endcase
                check_field("status", 32'(want.st), 32'(status));
                check_field("written_reg", 32'(want.reg_no), 32'(written_reg));
                check_field("result_word", 32'(want.word), 32'(result_word));
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog on cycles with no transfer on either channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
